@@ src/bf5_pkg.sv @@
package bf5_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int WIN         = 5;
    localparam int LINES       = WIN - 1;
    localparam int HALF        = WIN / 2;
    localparam int PIX_W       = 8;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int COL_W       = ADDR_W;
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int COLSUM_W    = 11;
    localparam int WINSUM_W    = 13;
    localparam int LINE_DATA_W = LINES * PIX_W;

    // floor(s / 25) == (s * 5243) >> 17 for every s up to 25 * 255
    localparam int RECIP       = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = WINSUM_W + RECIP_W;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             last;
        logic [COL_W-1:0] cx;
        logic [ROW_W-1:0] cy;
    } tag_t;

    typedef logic [WIN-1:0][PIX_W-1:0] column_t;

endpackage

@@ src/bf5_window_sum.sv @@
module bf5_window_sum
    import bf5_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  tag_t               col_tag,
    input  column_t            col_pixels,
    output tag_t               res_tag,
    output logic [PIX_W-1:0]   res_mean
);

    logic [COLSUM_W-1:0] colsum;
    logic [COLSUM_W-1:0] cs_reg [WIN];
    logic [WINSUM_W-1:0] winsum;
    tag_t                t2_reg;
    tag_t                t3_reg;
    tag_t                t4_reg;
    logic [WINSUM_W-1:0] sum_reg;
    logic [PROD_W-1:0]   prod;
    logic [PIX_W-1:0]    mean_reg;

    always_comb
    begin
        colsum = '0;
        for (int r = 0; r < WIN; r++)
        begin
            colsum = colsum + COLSUM_W'(col_pixels[r]);
        end
    end

    always_comb
    begin
        winsum = '0;
        for (int c = 0; c < WIN; c++)
        begin
            winsum = winsum + WINSUM_W'(cs_reg[c]);
        end
    end

    assign prod = PROD_W'(sum_reg) * PROD_W'(RECIP);

    // window kept as column sums, oldest column at index 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < WIN; c++)
            begin
                cs_reg[c] <= '0;
            end
        end
        else if (adv && col_tag.valid)
        begin
            for (int c = 0; c < WIN - 1; c++)
            begin
                cs_reg[c] <= cs_reg[c+1];
            end
            cs_reg[WIN-1] <= colsum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
        end
        else if (adv)
        begin
            t2_reg <= col_tag;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg  <= winsum;
            mean_reg <= prod[RECIP_SHIFT +: PIX_W];
        end
    end

    assign res_tag  = t4_reg;
    assign res_mean = mean_reg;

endmodule

@@ src/box_filter_5x5_stream_core.sv @@
// pipeline: s1, column sums, window sum, mean, then the output register
// throughput: one pixel per cycle if not held; the line store is read at accept
// and written from s1, with a bypass when the same column comes twice in a row
// the whole pipeline holds while a result waits on out_ready
// reset: position to row 0 column 0, window to zero, width 640, height 480;
// line store contents are not cleared
module box_filter_5x5_stream_core
    import bf5_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      mean_value,
    output logic [COL_W-1:0]      centre_x,
    output logic [ROW_W-1:0]      centre_y,
    output logic                  last_of_frame,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [COL_W-1:0]    wm1_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [ROW_W-1:0]    hm1_reg;
    logic [WIDTH_W-1:0]  width_next;
    logic [HEIGHT_W-1:0] height_next;

    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_next;

    logic                adv;
    logic                accept;
    logic [COL_W-1:0]    x0;
    logic [ROW_W-1:0]    y0;
    logic [HEIGHT_W-1:0] y_inc;
    logic [COL_W-1:0]    x;
    logic [ROW_W-1:0]    y;
    logic [WIDTH_W-1:0]  x_adv;
    logic [HEIGHT_W-1:0] y_adv;

    tag_t                s1_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic [PIX_W-1:0]    s1_px_reg;
    logic                s1_fwd_reg;

    logic [LINE_DATA_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_DATA_W-1:0] rdata_reg;
    logic [LINE_DATA_W-1:0] wlast_reg;
    logic [LINE_DATA_W-1:0] above;
    logic [LINE_DATA_W-1:0] wdata;
    logic                   wr_en;
    column_t                col_pixels;

    tag_t                res_tag;
    logic [PIX_W-1:0]    res_mean;

    logic                out_valid_reg;
    logic [PIX_W-1:0]    mean_reg;
    logic [COL_W-1:0]    cx_reg;
    logic [ROW_W-1:0]    cy_reg;
    logic                last_reg;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign accept    = in_valid && adv;

    // registers are stored already clamped to their legal range
    always_comb
    begin
        width_next = cfg_data[WIDTH_W-1:0];
        if (width_next < WIDTH_W'(WIN))
        begin
            width_next = WIDTH_W'(WIN);
        end
        else if (width_next > WIDTH_W'(MAX_WIDTH))
        begin
            width_next = WIDTH_W'(MAX_WIDTH);
        end
        height_next = cfg_data[HEIGHT_W-1:0];
        if (height_next < HEIGHT_W'(WIN))
        begin
            height_next = HEIGHT_W'(WIN);
        end
        else if (height_next > HEIGHT_W'(MAX_HEIGHT))
        begin
            height_next = HEIGHT_W'(MAX_HEIGHT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            wm1_reg    <= COL_W'(WIDTH_RESET - 1'b1);
            height_reg <= HEIGHT_RESET;
            hm1_reg    <= ROW_W'(HEIGHT_RESET - 1'b1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    width_reg <= width_next;
                    wm1_reg   <= COL_W'(width_next - 1'b1);
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_reg <= height_next;
                    hm1_reg    <= ROW_W'(height_next - 1'b1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // raster position of the incoming pixel and the one after it
    always_comb
    begin
        x0    = frame_start ? '0 : col_reg;
        y0    = frame_start ? '0 : row_reg;
        x     = x0;
        y_inc = {1'b0, y0};
        if ({1'b0, x0} >= width_reg)
        begin
            x     = '0;
            y_inc = y_inc + 1'b1;
        end
        y = (y_inc >= height_reg) ? '0 : y_inc[ROW_W-1:0];

        x_adv    = {1'b0, x} + 1'b1;
        y_adv    = {1'b0, y} + 1'b1;
        col_next = x + 1'b1;
        row_next = y;
        if (x_adv >= width_reg)
        begin
            col_next = '0;
            row_next = (y_adv >= height_reg) ? '0 : y_adv[ROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            s1_reg  <= '0;
        end
        else if (adv)
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_reg.valid <= accept;
            s1_reg.emit  <= (x >= COL_W'(LINES)) && (y >= ROW_W'(LINES));
            s1_reg.last  <= (x == wm1_reg) && (y == hm1_reg);
            s1_reg.cx    <= x - COL_W'(LINES - HALF);
            s1_reg.cy    <= y - ROW_W'(LINES - HALF);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= x;
            s1_px_reg   <= pixel;
            // the item ahead writes this column in the same cycle as the read
            s1_fwd_reg  <= s1_reg.valid && (s1_addr_reg == x);
        end
    end

    // column build and write-back
    assign above = s1_fwd_reg ? wlast_reg : rdata_reg;
    assign wr_en = adv && s1_reg.valid;

    always_comb
    begin
        for (int r = 0; r < LINES; r++)
        begin
            col_pixels[r] = above[r*PIX_W +: PIX_W];
        end
        col_pixels[LINES] = s1_px_reg;
        for (int r = 0; r < LINES; r++)
        begin
            wdata[r*PIX_W +: PIX_W] = col_pixels[r+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[s1_addr_reg] <= wdata;
            wlast_reg             <= wdata;
        end
        if (accept)
        begin
            rdata_reg <= line_mem[x];
        end
    end

    bf5_window_sum u_window_sum
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .col_tag    (s1_reg),
        .col_pixels (col_pixels),
        .res_tag    (res_tag),
        .res_mean   (res_mean)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res_tag.valid && res_tag.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mean_reg <= res_mean;
            cx_reg   <= res_tag.cx;
            cy_reg   <= res_tag.cy;
            last_reg <= res_tag.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mean_value    = mean_reg;
    assign centre_x      = cx_reg;
    assign centre_y      = cy_reg;
    assign last_of_frame = last_reg;

endmodule
